>>> hdl/tkl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_pkg
// Shared types and codes for the top-K largest value tracker.
// ----------------------------------------------------------------------------
package tkl_pkg;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef struct packed {
        logic ins;
        logic rd_start;
        logic rd_next;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic out_last;
    } t_dp_status;

endpackage

>>> hdl/tkl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_datapath
// Sorted store of the largest values, parallel insert and indexed readout.
// ----------------------------------------------------------------------------
module tkl_datapath
    import tkl_pkg::*;
#(
    parameter int KEEP_COUNT = 10,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output t_dp_status                   o_status,
    output logic        [VALUE_BITS-1:0] o_out_value
);

    localparam int CW   = $clog2(KEEP_COUNT + 1);
    localparam int IDXW = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

    logic signed [VALUE_BITS-1:0] r_kept [KEEP_COUNT];
    logic signed [VALUE_BITS-1:0] n_kept [KEEP_COUNT];
    logic        [CW-1:0]         r_count, n_count;
    logic        [IDXW-1:0]       r_idx, n_idx;
    logic        [VALUE_BITS-1:0] r_out_value, n_out_value;
    logic                         r_out_last, n_out_last;

    logic                         ge      [KEEP_COUNT];
    logic                         prev_ge [KEEP_COUNT];
    logic signed [VALUE_BITS-1:0] prev_val [KEEP_COUNT];
    logic                         up_ge   [KEEP_COUNT];
    logic signed [VALUE_BITS-1:0] up_val  [KEEP_COUNT];
    logic                         full;
    logic                         beats_min;
    logic        [IDXW-1:0]       start_idx;
    logic        [IDXW-1:0]       next_idx;

    assign full      = (r_count == CW'(KEEP_COUNT));
    assign beats_min = (i_value > r_kept[0]);
    assign start_idx = IDXW'(r_count - CW'(1));
    assign next_idx  = r_idx - IDXW'(1);

    for (genvar g = 0; g < KEEP_COUNT; g++) begin : g_entry
        assign ge[g] = (CW'(g) < r_count) && (i_value >= r_kept[g]);
        if (g == 0) begin : g_first
            assign prev_ge[g]  = 1'b1;
            assign prev_val[g] = i_value;
        end else begin : g_mid
            assign prev_ge[g]  = ge[g-1];
            assign prev_val[g] = r_kept[g-1];
        end
        if (g == KEEP_COUNT - 1) begin : g_top
            assign up_ge[g]  = 1'b0;
            assign up_val[g] = r_kept[g];
        end else begin : g_below
            assign up_ge[g]  = ge[g+1];
            assign up_val[g] = r_kept[g+1];
        end
    end

    always_comb begin
        n_kept      = r_kept;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        if (i_cmd.ins) begin
            if (!full) begin
                for (int i = 0; i < KEEP_COUNT; i++) begin
                    n_kept[i] = ge[i] ? r_kept[i] : (prev_ge[i] ? i_value : prev_val[i]);
                end
                n_count = r_count + CW'(1);
            end else if (beats_min) begin
                // drop the smallest, slide lower entries down, place the value
                for (int i = 0; i < KEEP_COUNT; i++) begin
                    n_kept[i] = up_ge[i] ? up_val[i] : (ge[i] ? i_value : r_kept[i]);
                end
            end
        end
        if (i_cmd.rd_start) begin
            n_idx       = start_idx;
            n_out_value = r_kept[start_idx];
            n_out_last  = (r_count == CW'(1));
        end else if (i_cmd.rd_next) begin
            n_idx       = next_idx;
            n_out_value = r_kept[next_idx];
            n_out_last  = (r_idx == IDXW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_kept      <= n_kept;
        r_idx       <= n_idx;
        r_out_value <= n_out_value;
        if (!i_rst_n) begin
            r_count    <= '0;
            r_out_last <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_out_last <= n_out_last;
        end
    end

    assign o_status.empty    = (r_count == '0);
    assign o_status.out_last = r_out_last;
    assign o_out_value       = r_out_value;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(KEEP_COUNT))
        else $error("held count above capacity");

    a_ins_no_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins |=> r_count >= $past(r_count))
        else $error("insert reduced the held count");

    a_no_step_past_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_next |-> !r_out_last)
        else $error("readout stepped beyond the smallest entry");

    a_start_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_start |-> r_count != '0)
        else $error("readout started on an empty store");

endmodule

>>> hdl/tkl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_ctrl
// Handshake controller: takes items, issues insert and readout commands.
// ----------------------------------------------------------------------------
module tkl_ctrl
    import tkl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_func,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_xfer;
    logic   out_xfer;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_valid && i_out_ready;

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid;
        o_cmd.ins      = 1'b0;
        o_cmd.rd_start = 1'b0;
        o_cmd.rd_next  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_func == FUNC_INSERT) begin
                        o_cmd.ins = 1'b1;
                    end else if (!i_status.empty) begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_READ;
                        n_out_valid    = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (out_xfer) begin
                    if (i_status.out_last) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b0;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_valid_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid == (r_state == S_READ))
        else $error("output valid out of step with readout state");

    a_start_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_start |=> o_out_valid)
        else $error("readout start did not present a result");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && i_status.out_last) |=> r_state == S_IDLE)
        else $error("readout did not end after the last transfer");

endmodule

>>> hdl/top_k_largest_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_largest_tracker_core
// Keeps the KEEP_COUNT largest signed values of a stream in sorted order and
// reads them out largest first.
//
// Channel   Dir  Signals                          Content
// s_axis    in   tvalid tready tdata tuser        tdata: value; tuser: func
// m_axis    out  tvalid tready tdata tlast        tdata: value_out; tlast: last
//
// Insert: input stays ready, no result.
// Read: one result per held value, one per cycle while m_axis is ready; input
// is held off until the last result transfers. An empty store gives no result.
// The readout pace is set by the single indexed read of the sorted store.
// Reset clears the held count; synchronous, active low.
// ----------------------------------------------------------------------------
module top_k_largest_tracker_core
    import tkl_pkg::*;
#(
    parameter int KEEP_COUNT = 10,
    parameter int VALUE_BITS = 32,
    localparam int TDATA_W   = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,   // [VALUE_BITS-1:0] value
    input  logic               i_s_axis_tuser,   // [0] func
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // [VALUE_BITS-1:0] value_out
    output logic               o_m_axis_tlast
);

    t_dp_cmd                      cmd;
    t_dp_status                   status;
    logic        [VALUE_BITS-1:0] out_value;
    logic signed [VALUE_BITS-1:0] in_value;

    assign in_value = $signed(i_s_axis_tdata[VALUE_BITS-1:0]);

    tkl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_func   (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tkl_datapath #(
        .KEEP_COUNT (KEEP_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (in_value),
        .o_status    (status),
        .o_out_value (out_value)
    );

    assign o_m_axis_tdata = TDATA_W'(out_value);
    assign o_m_axis_tlast = status.out_last;

endmodule
